// ===== design/ffba_pkg.sv =====
// Package with shared constants, types and codes of the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;
  localparam int unsigned MaxSegmentsDefault = 64;
  localparam int unsigned HeaderBytesDefault = 16;
  localparam int unsigned ArenaLimit         = 65536;

  localparam logic       ReqAlloc = 1'b0;
  localparam logic       ReqFree  = 1'b1;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoFit   = 2'd1;
  localparam logic [1:0] StatusUnknown = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OpNone,
    OpInit,
    OpLatch,
    OpRead,
    OpNext,
    OpTake,
    OpSplitStart,
    OpUpRead,
    OpUpWrite,
    OpSplitLow,
    OpSplitHigh,
    OpFreeHit,
    OpMergePrev,
    OpDownRead,
    OpDownWrite,
    OpShrink,
    OpReadNext,
    OpMergeNext,
    OpPutCur,
    OpPresent
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_end;   // scan index has reached the segment count
    logic hit;        // the entry just read matches the request
    logic can_split;  // the hit entry should be split
    logic prev_free;  // predecessor exists and is free
    logic has_next;   // a successor of the current entry exists
    logic next_free;  // the successor just read is free
    logic up_end;     // opening a slot for a split is finished
    logic down_end;   // closing the slot of a removed entry is finished
  } dp_status_t;
endpackage

// ===== design/ffba_if.sv =====
// Valid/ready channel interface carrying a request or a result.
`timescale 1ns / 1ps
interface ffba_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/ffba_datapath.sv =====
// Segment table memory, scan registers and arithmetic of the allocator.
`timescale 1ns / 1ps
module ffba_datapath #(
  parameter int unsigned MaxSegments = ffba_pkg::MaxSegmentsDefault,
  parameter int unsigned HeaderBytes = ffba_pkg::HeaderBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffba_pkg::ctrl_cmd_t cmd_i,
  output ffba_pkg::dp_status_t status_o,
  input  logic [16:0]         arena_bytes_i,
  input  logic                req_type_i,
  input  logic [16:0]         alloc_size_i,
  input  logic [15:0]         free_address_i,
  output logic [15:0]         address_o,
  output logic [1:0]          status_code_o
);
  import ffba_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam logic [16:0] Hdr  = 17'(HeaderBytes);

  typedef struct packed {
    logic [15:0] off;
    logic [16:0] pay;
    logic        used;
  } seg_t;

  // The table lives in a memory with one registered read and one write per
  // cycle; the entry under work and its predecessor are kept in registers.
  seg_t            seg_q [MaxSegments];
  seg_t            rd_q, cur_q, prev_q, wdata;
  logic [IdxW-1:0] raddr, waddr;
  logic            mem_re, mem_we;
  logic [CntW-1:0] cnt_q, idx_q, sh_q;
  logic [CntW-1:0] idx_inc, sh_inc, sh_dec;
  logic            type_q;
  logic [16:0]     size_q;
  logic [15:0]     faddr_q;
  logic [15:0]     addr_q, res_addr_q;
  logic [1:0]      code_q, res_code_q;
  logic [17:0]     need;
  logic [16:0]     arena_c;
  logic [16:0]     init_pay;

  assign idx_inc  = idx_q + CntW'(1);
  assign sh_inc   = sh_q + CntW'(1);
  assign sh_dec   = sh_q - CntW'(1);
  assign need     = 18'(size_q) + 18'(Hdr);
  assign arena_c  = (arena_bytes_i > 17'(ArenaLimit)) ? 17'(ArenaLimit) : arena_bytes_i;
  assign init_pay = (arena_c > Hdr) ? arena_c - Hdr : '0;

  always_comb begin
    status_o.scan_end = (idx_q >= cnt_q);
    if (type_q == ReqFree) begin
      status_o.hit = (17'(rd_q.off) + Hdr) == {1'b0, faddr_q};
    end else begin
      status_o.hit = !rd_q.used && (rd_q.pay >= size_q);
    end
    status_o.can_split = (18'(rd_q.pay) > need) && (cnt_q < CntW'(MaxSegments));
    status_o.prev_free = (idx_q != '0) && !prev_q.used;
    status_o.has_next  = (idx_inc < cnt_q);
    status_o.next_free = !rd_q.used;
    status_o.up_end    = (sh_q <= idx_inc);
    status_o.down_end  = (sh_inc >= cnt_q);
  end

  // Memory port selection.
  always_comb begin
    mem_re = 1'b0;
    raddr  = idx_q[IdxW-1:0];
    mem_we = 1'b0;
    waddr  = idx_q[IdxW-1:0];
    wdata  = cur_q;
    case (cmd_i.op)
      OpInit: begin
        mem_we = 1'b1;
        waddr  = '0;
        wdata  = {16'd0, init_pay, 1'b0};
      end
      OpRead: begin
        mem_re = 1'b1;
      end
      OpReadNext: begin
        mem_re = 1'b1;
        raddr  = idx_inc[IdxW-1:0];
      end
      OpUpRead: begin
        mem_re = 1'b1;
        raddr  = sh_dec[IdxW-1:0];
      end
      OpUpWrite: begin
        mem_we = 1'b1;
        waddr  = sh_q[IdxW-1:0];
        wdata  = rd_q;
      end
      OpDownRead: begin
        mem_re = 1'b1;
        raddr  = sh_inc[IdxW-1:0];
      end
      OpDownWrite: begin
        mem_we = 1'b1;
        waddr  = sh_q[IdxW-1:0];
        wdata  = rd_q;
      end
      OpTake: begin
        mem_we = 1'b1;
        wdata  = {rd_q.off, rd_q.pay, 1'b1};
      end
      OpSplitLow: begin
        mem_we = 1'b1;
        waddr  = idx_inc[IdxW-1:0];
        wdata  = {16'(17'(cur_q.off) + Hdr + size_q), 17'(cur_q.pay - size_q - Hdr), 1'b0};
      end
      OpSplitHigh: begin
        mem_we = 1'b1;
        wdata  = {cur_q.off, size_q, 1'b1};
      end
      OpPutCur: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) seg_q[waddr] <= wdata;
    if (mem_re) rd_q <= seg_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= CntW'(1);
      idx_q      <= '0;
      sh_q       <= '0;
      cur_q      <= '0;
      prev_q     <= '0;
      type_q     <= ReqAlloc;
      size_q     <= '0;
      faddr_q    <= '0;
      addr_q     <= '0;
      code_q     <= StatusOk;
      res_addr_q <= '0;
      res_code_q <= StatusOk;
    end else begin
      case (cmd_i.op)
        OpInit: begin
          cnt_q <= CntW'(1);
        end
        OpLatch: begin
          type_q  <= req_type_i;
          size_q  <= alloc_size_i;
          faddr_q <= free_address_i;
          idx_q   <= '0;
          addr_q  <= '0;
          code_q  <= (req_type_i == ReqFree) ? StatusUnknown : StatusNoFit;
        end
        OpNext: begin
          prev_q <= rd_q;
          idx_q  <= idx_inc;
        end
        OpTake: begin
          addr_q <= 16'(17'(rd_q.off) + Hdr);
          code_q <= StatusOk;
        end
        OpSplitStart: begin
          cur_q <= rd_q;
          sh_q  <= cnt_q;
        end
        OpUpWrite: begin
          sh_q <= sh_dec;
        end
        OpSplitLow: begin
          cnt_q <= cnt_q + CntW'(1);
        end
        OpSplitHigh: begin
          addr_q <= 16'(17'(cur_q.off) + Hdr);
          code_q <= StatusOk;
        end
        OpFreeHit: begin
          cur_q  <= {rd_q.off, rd_q.pay, 1'b0};
          code_q <= StatusOk;
        end
        OpMergePrev: begin
          cur_q  <= {prev_q.off, 17'(prev_q.pay + rd_q.pay + Hdr), 1'b0};
          idx_q  <= idx_q - CntW'(1);
          sh_q   <= idx_q;
          code_q <= StatusOk;
        end
        OpDownWrite: begin
          sh_q <= sh_inc;
        end
        OpShrink: begin
          cnt_q <= cnt_q - CntW'(1);
        end
        OpMergeNext: begin
          cur_q.pay <= cur_q.pay + rd_q.pay + Hdr;
          sh_q      <= idx_inc;
        end
        OpPresent: begin
          res_addr_q <= addr_q;
          res_code_q <= code_q;
        end
        default: ;
      endcase
    end
  end

  assign address_o     = res_addr_q;
  assign status_code_o = res_code_q;
endmodule

// ===== design/ffba_controller.sv =====
// Sequencing state machine of the allocator.
`timescale 1ns / 1ps
module ffba_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  logic                 req_type_i,
  input  ffba_pkg::dp_status_t status_i,
  output ffba_pkg::ctrl_cmd_t  cmd_o
);
  import ffba_pkg::*;

  typedef enum logic [3:0] {
    StInit, StIdle, StRead, StCheck, StUpRd, StUpWr, StSplitHi, StDownRdP, StDownWrP,
    StNext, StNextCheck, StDownRdN, StDownWrN, StPut, StOut
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // A new request may be taken while the previous result is still held.
  assign in_ready_o  = (state_q == StIdle) && !cfg_we_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OpNone;
    case (state_q)
      StInit: begin
        cmd_o.op = OpInit;
        state_d  = StIdle;
      end
      StIdle: begin
        if (cfg_we_i) begin
          cmd_o.op = OpInit;
        end else if (in_valid_i && in_ready_o) begin
          cmd_o.op = OpLatch;
          state_d  = StRead;
        end
      end
      StRead: begin
        if (status_i.scan_end) begin
          state_d = StOut;
        end else begin
          cmd_o.op = OpRead;
          state_d  = StCheck;
        end
      end
      StCheck: begin
        if (status_i.hit) begin
          if (req_type_i == ReqFree) begin
            if (status_i.prev_free) begin
              cmd_o.op = OpMergePrev;
              state_d  = StDownRdP;
            end else begin
              cmd_o.op = OpFreeHit;
              state_d  = StNext;
            end
          end else if (status_i.can_split) begin
            cmd_o.op = OpSplitStart;
            state_d  = StUpRd;
          end else begin
            cmd_o.op = OpTake;
            state_d  = StOut;
          end
        end else begin
          cmd_o.op = OpNext;
          state_d  = StRead;
        end
      end
      StUpRd: begin
        if (status_i.up_end) begin
          cmd_o.op = OpSplitLow;
          state_d  = StSplitHi;
        end else begin
          cmd_o.op = OpUpRead;
          state_d  = StUpWr;
        end
      end
      StUpWr: begin
        cmd_o.op = OpUpWrite;
        state_d  = StUpRd;
      end
      StSplitHi: begin
        cmd_o.op = OpSplitHigh;
        state_d  = StOut;
      end
      StDownRdP: begin
        if (status_i.down_end) begin
          cmd_o.op = OpShrink;
          state_d  = StNext;
        end else begin
          cmd_o.op = OpDownRead;
          state_d  = StDownWrP;
        end
      end
      StDownWrP: begin
        cmd_o.op = OpDownWrite;
        state_d  = StDownRdP;
      end
      StNext: begin
        if (status_i.has_next) begin
          cmd_o.op = OpReadNext;
          state_d  = StNextCheck;
        end else begin
          state_d = StPut;
        end
      end
      StNextCheck: begin
        if (status_i.next_free) begin
          cmd_o.op = OpMergeNext;
          state_d  = StDownRdN;
        end else begin
          state_d = StPut;
        end
      end
      StDownRdN: begin
        if (status_i.down_end) begin
          cmd_o.op = OpShrink;
          state_d  = StPut;
        end else begin
          cmd_o.op = OpDownRead;
          state_d  = StDownWrN;
        end
      end
      StDownWrN: begin
        cmd_o.op = OpDownWrite;
        state_d  = StDownRdN;
      end
      StPut: begin
        cmd_o.op = OpPutCur;
        state_d  = StOut;
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OpPresent;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

// ===== design/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator with coalescing.
// Operation: each table entry is scanned with a read and a check, and each entry moved
// when a split opens a slot or a merge closes one takes a read and a write, followed by
// the split, merge and write-back steps and the presenting of the result.
// Throughput: one request at a time; the result waits in its own register, so the next
// request is taken while it is still held. Reset: asynchronous, active low; right after
// reset the table is written as one free segment over the 65536-byte arena, requests held off.
`timescale 1ns / 1ps
module first_fit_block_allocator #(
  parameter int unsigned MaxSegments = ffba_pkg::MaxSegmentsDefault,
  parameter int unsigned HeaderBytes = ffba_pkg::HeaderBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  ffba_if.sink        req,
  ffba_if.source      rsp
);
  import ffba_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dps;
  logic [16:0] arena_q;
  logic [15:0] address;
  logic [1:0]  status_code;
  logic        type_q;

  // The arena size register; a write while the controller is idle reinitialises the table in the
  // same cycle through the controller, which reads the data straight from the port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q <= 17'(ArenaLimit);
      type_q  <= ReqAlloc;
    end else begin
      if (cfg_we_i) arena_q <= cfg_wdata_i;
      if (req.valid && req.ready) type_q <= req.payload.req_type;
    end
  end

  ffba_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .req_type_i  (type_q),
    .status_i    (dps),
    .cmd_o       (cmd)
  );

  ffba_datapath #(
    .MaxSegments (MaxSegments),
    .HeaderBytes (HeaderBytes)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dps),
    .arena_bytes_i  (cfg_we_i ? cfg_wdata_i : arena_q),
    .req_type_i     (req.payload.req_type),
    .alloc_size_i   (req.payload.alloc_size),
    .free_address_i (req.payload.free_address),
    .address_o      (address),
    .status_code_o  (status_code)
  );

  assign rsp.payload.address = address;
  assign rsp.payload.status  = status_code;
endmodule
